### hw/rtl/tblf_pkg.sv
// Package: shared types and constants for the Thumb branch-link fixup block.
package tblf_pkg;

	// Halfword layout of a BL pair
	localparam int HW_W      = 16;
	localparam int TAG_W     = 5;
	localparam int IMM_W     = 11;
	localparam int OFFSET_W  = 23;
	localparam int POS_USED  = OFFSET_W - 1;

	localparam logic [TAG_W-1:0] PREFIX_TAG = 5'b11110;
	localparam logic [TAG_W-1:0] SUFFIX_TAG = 5'b11111;

	// Result queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef struct packed {
		logic [HW_W-1:0] halfword;
		logic            last;
	} tblf_beat_t;

	// Up to two results per request: held word first, then the last word
	typedef struct packed {
		logic       vld0;
		tblf_beat_t beat0;
		logic       vld1;
		tblf_beat_t beat1;
	} tblf_push_t;

	typedef struct packed {
		logic held_valid;
		logic pos_zero;
	} tblf_fix_stat_t;

	typedef struct packed {
		logic [Q_CW-1:0] count;
	} tblf_q_stat_t;

endpackage

### hw/rtl/tblf_in_if.sv
// Interface: input channel carrying code halfword requests.
interface tblf_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] halfword;
	logic        last;

	modport source (output valid, output halfword, output last, input ready);
	modport sink   (input valid, input halfword, input last, output ready);
endinterface

### hw/rtl/tblf_out_if.sv
// Interface: output channel carrying fixed-up halfword requests.
interface tblf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_halfword;
	logic        out_last;

	modport source (output valid, output out_halfword, output out_last, input ready);
	modport sink   (input valid, input out_halfword, input out_last, output ready);
endinterface

### hw/rtl/tblf_fixup.sv
// Module: held-word and position state plus the BL pair re-encoding logic.
module tblf_fixup
	import tblf_pkg::*;
#(
	parameter int POSITION_WIDTH = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [HW_W-1:0]     halfword,
	input  logic                last,
	output tblf_push_t          push,
	output tblf_fix_stat_t      stat
);

	logic [HW_W-1:0]           held_q;
	logic                      held_valid_q;
	logic [POSITION_WIDTH-1:0] pos_q;

	logic                  pair_hit;
	logic [OFFSET_W-1:0]   joined;
	logic [OFFSET_W-1:0]   twice;
	logic [OFFSET_W-1:0]   rel;
	logic [HW_W-1:0]       prev_fix;
	logic [HW_W-1:0]       cur_fix;

	always_comb begin
		pair_hit = (halfword[HW_W-1 -: TAG_W] == SUFFIX_TAG) &&
		           (held_q[HW_W-1 -: TAG_W] == PREFIX_TAG);
		joined   = {held_q[IMM_W-1:0], halfword[IMM_W-1:0], 1'b0};
		twice    = {pos_q[POS_USED-1:0], 1'b0};
		rel      = joined - twice;
		if (pair_hit) begin
			prev_fix = {PREFIX_TAG, rel[OFFSET_W-1 -: IMM_W]};
			cur_fix  = {SUFFIX_TAG, rel[IMM_W:1]};
		end else begin
			prev_fix = held_q;
			cur_fix  = halfword;
		end
		push.vld0  = accept && held_valid_q;
		push.beat0 = '{halfword: prev_fix, last: 1'b0};
		push.vld1  = accept && last;
		push.beat1 = '{halfword: cur_fix, last: 1'b1};
		stat.held_valid = held_valid_q;
		stat.pos_zero   = (pos_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			pos_q        <= '0;
		end else if (accept) begin
			if (last) begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
				pos_q        <= '0;
			end else begin
				held_q       <= cur_fix;
				held_valid_q <= 1'b1;
				pos_q        <= pos_q + POSITION_WIDTH'(1);
			end
		end
	end

endmodule

### hw/rtl/tblf_queue.sv
// Module: four-entry result queue taking up to two pushes per cycle.
module tblf_queue
	import tblf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  tblf_push_t    push,
	input  logic          pop,
	output tblf_beat_t    head,
	output logic          not_empty,
	output logic          space,
	output tblf_q_stat_t  stat
);

	tblf_beat_t      mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	logic [Q_AW-1:0] idx1;
	logic [Q_CW-1:0] n_push;
	logic            do_pop;

	always_comb begin
		idx1      = wr_ptr_q + Q_AW'(push.vld0);
		n_push    = Q_CW'(push.vld0) + Q_CW'(push.vld1);
		not_empty = (count_q != '0);
		do_pop    = pop && not_empty;
		head      = mem_q[rd_ptr_q];
		// room for two pushes regardless of a pop this cycle
		space     = (count_q <= Q_CW'(Q_DEPTH - 2));
		stat.count = count_q;
	end

	always_ff @(posedge clk) begin
		if (push.vld0) begin
			mem_q[wr_ptr_q] <= push.beat0;
		end
		if (push.vld1) begin
			mem_q[idx1] <= push.beat1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(n_push);
			rd_ptr_q <= rd_ptr_q + Q_AW'(do_pop);
			count_q  <= count_q + n_push - Q_CW'(do_pop);
		end
	end

endmodule

### hw/rtl/thumb_branch_link_fixup_top.sv
// Top level: Thumb BL pair fixup, absolute targets rewritten as relative offsets.
//
// A stream of 16-bit Thumb halfwords enters on "code" and leaves on "fixed".
// Each halfword is held until the next one arrives; when the held word is a
// BL prefix (top bits 11110) and the new one a BL suffix (top bits 11111),
// the 23-bit joined offset minus twice the suffix's position is written back
// into both halves. Output therefore lags input by one request: the first
// halfword of a block gives no result, and the halfword marked last flushes
// the held word (out_last 0) and then itself (out_last 1), after which the
// position restarts at 0. One halfword request is taken every clock cycle
// while the queue has room for two results; results go into a four-entry
// queue whose head drives "fixed" directly. A last request pushes two
// results, so the queue holds an extra result to drain after each block.
// The position counter is POSITION_WIDTH bits and wraps; only its low 22
// bits enter the offset arithmetic.
module thumb_branch_link_fixup_top
	import tblf_pkg::*;
#(
	parameter int POSITION_WIDTH = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	tblf_in_if.sink    code,
	tblf_out_if.source fixed
);

	logic           accept;
	logic           space;
	logic           not_empty;
	tblf_push_t     push;
	tblf_beat_t     head;
	tblf_fix_stat_t fix_stat;
	tblf_q_stat_t   q_stat;

	assign code.ready = space;
	assign accept     = code.valid && space;

	// held word, position and the pair re-encoding
	tblf_fixup #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_fixup (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.halfword (code.halfword),
		.last     (code.last),
		.push     (push),
		.stat     (fix_stat)
	);

	// result queue decouples the output side from the input side
	tblf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (fixed.ready),
		.head      (head),
		.not_empty (not_empty),
		.space     (space),
		.stat      (q_stat)
	);

	assign fixed.valid        = not_empty;
	assign fixed.out_halfword = head.halfword;
	assign fixed.out_last     = head.last;

	// queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= Q_CW'(Q_DEPTH))
		else $error("result queue overflow");

	// a last request clears the held word and the position
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && code.last) |=> (!fix_stat.held_valid && fix_stat.pos_zero))
		else $error("block end did not clear held state");

	// a request that does not end a block leaves a word held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !code.last) |=> fix_stat.held_valid)
		else $error("halfword not held");

	// nothing held means position restarted
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!fix_stat.held_valid |-> fix_stat.pos_zero)
		else $error("position nonzero with empty hold");

endmodule
